[rtl/atrp_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the accelerometer tilt block.
// Used by accel_tilt_roll_pitch_top and its port checker; depends on nothing.
package atrp_pkg;

   localparam int TABLE_LEN = 24;

   // Register indexes of the configuration port.
   localparam logic REG_AXIS_GAIN = 1'b0;
   localparam logic REG_Z_OFFSET  = 1'b1;

   localparam logic [15:0]        GAIN_RESET   = 16'd9975;
   localparam logic signed [15:0] OFFSET_RESET = 16'sd282;

   // Angles inside the CORDIC are in 1/32768 degree.
   localparam logic signed [24:0] DEG90 = 25'sd2949120;
   localparam logic signed [16:0] ROLL_LIMIT  = 17'sd23040;
   localparam logic signed [16:0] PITCH_LIMIT = 17'sd11520;

   // Rounded atan(2^-i) in 1/32768 degree.
   localparam logic signed [24:0] ATAN_TAB [0:TABLE_LEN-1] = '{
      25'sd1474560, 25'sd870484, 25'sd459940, 25'sd233473, 25'sd117189, 25'sd58652,
      25'sd29333, 25'sd14667, 25'sd7334, 25'sd3667, 25'sd1833, 25'sd917,
      25'sd458, 25'sd229, 25'sd115, 25'sd57, 25'sd29, 25'sd14,
      25'sd7, 25'sd4, 25'sd2, 25'sd1, 25'sd0, 25'sd0
   };

   typedef struct packed {
      logic signed [27:0] x;
      logic signed [27:0] y;
      logic signed [24:0] ang;
      logic               zero;
   } lane_type;

   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic [47:0]        rem;
      logic [23:0]        q;
   } sq_type;

   typedef struct packed {
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      lane_type           roll;
      lane_type           pitch;
   } cr_type;

endpackage

[rtl/accel_tilt_roll_pitch_top.sv]
`timescale 1ns / 1ps
// Accelerometer tilt pipeline: axis scaling, magnitude square root and two CORDIC lanes.
// Depends on atrp_pkg.
//
// One sample word enters per clock and one result word leaves per clock while the receiver
// accepts results. The pipeline has one stage each for the gain multiply, saturation and
// squaring, one for the sum, one per bit of the 24-bit square root, one for the quadrant
// turn, one per CORDIC iteration (roll and pitch run side by side) and one output register.
// Every stage has its own valid bit, so a stalled output only holds back the stages that are
// full, and bubbles close up behind it. Configuration writes take effect at once and should
// be made while no sample is in flight.
module accel_tilt_roll_pitch_top #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // raw_x[15:0], raw_y[31:16], raw_z[47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // accel_x_out[15:0], accel_y_out[31:16], accel_z_out[47:32], roll_out[63:48],
   // pitch_out[78:64], zero[79]
   output logic [79:0] rsp_tdata,
   input  logic        csr_we,
   input  logic        csr_addr,
   input  logic [15:0] csr_wdata
);

   localparam int NSTEPS  = (CORDIC_STEPS > atrp_pkg::TABLE_LEN) ? atrp_pkg::TABLE_LEN
                                                                  : CORDIC_STEPS;
   localparam int SQ_BASE = 3;
   localparam int CR_BASE = SQ_BASE + 25;
   localparam int NST     = CR_BASE + NSTEPS + 2;

   logic [15:0]        gain_ff;
   logic signed [15:0] offset_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= atrp_pkg::GAIN_RESET;
         offset_ff <= atrp_pkg::OFFSET_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            atrp_pkg::REG_AXIS_GAIN: gain_ff   <= csr_wdata;
            atrp_pkg::REG_Z_OFFSET:  offset_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Stage handshake: a stage loads when it is empty or its successor loads.
   logic [NST-1:0] vld_ff;
   logic [NST-1:0] mv;

   always_comb begin
      mv[NST-1] = !vld_ff[NST-1] || rsp_tready;
      for (int k = NST - 2; k >= 0; k--) begin
         mv[k] = !vld_ff[k] || mv[k+1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (mv[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int k = 1; k < NST; k++) begin
            if (mv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   assign req_tready = mv[0];

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      if (v > 18'sd32767) begin
         return 16'sh7fff;
      end else if (v < -18'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   function automatic logic signed [15:0] scale(input logic signed [32:0] p);
      logic signed [33:0] t;
      t = 34'(p) + 34'sd32768;
      return sat16(t[33:16]);
   endfunction

   // Stage 0: gain multiply.
   logic signed [32:0] px_ff, py_ff, pz_ff;
   logic signed [32:0] gs;

   assign gs = 33'($signed({1'b0, gain_ff}));

   always_ff @(posedge clock) begin
      if (mv[0]) begin
         px_ff <= 33'($signed(req_tdata[15:0])) * gs;
         py_ff <= 33'($signed(req_tdata[31:16])) * gs;
         pz_ff <= 33'($signed(req_tdata[47:32])) * gs;
      end
   end

   // Stage 1: rounding, saturation and the Z offset.
   logic signed [15:0] ax_ff, ay_ff, az_ff;

   always_ff @(posedge clock) begin
      if (mv[1]) begin
         ax_ff <= scale(px_ff);
         ay_ff <= scale(py_ff);
         az_ff <= sat16(18'(scale(pz_ff)) + 18'(offset_ff));
      end
   end

   // Stage 2: squares of Y and Z.
   logic signed [15:0] ax2_ff, ay2_ff, az2_ff;
   logic signed [31:0] yy_ff, zz_ff;

   always_ff @(posedge clock) begin
      if (mv[2]) begin
         ax2_ff <= ax_ff;
         ay2_ff <= ay_ff;
         az2_ff <= az_ff;
         yy_ff  <= ay_ff * ay_ff;
         zz_ff  <= az_ff * az_ff;
      end
   end

   // Square root of (y^2 + z^2) * 65536, one result bit per stage, MSB first.
   atrp_pkg::sq_type sq_ff [0:24];

   always_ff @(posedge clock) begin
      if (mv[SQ_BASE]) begin
         sq_ff[0].ax  <= ax2_ff;
         sq_ff[0].ay  <= ay2_ff;
         sq_ff[0].az  <= az2_ff;
         sq_ff[0].rem <= {(32'(yy_ff) + 32'(zz_ff)), 16'd0};
         sq_ff[0].q   <= '0;
      end
   end

   for (genvar j = 0; j < 24; j++) begin : g_sqrt
      localparam int BIT = 23 - j;
      logic [47:0] tst;
      atrp_pkg::sq_type sq_in;

      always_comb begin
         tst   = ({24'd0, sq_ff[j].q} << (BIT + 1)) + (48'd1 << (2 * BIT));
         sq_in = sq_ff[j];
         if (sq_ff[j].rem >= tst) begin
            sq_in.rem = sq_ff[j].rem - tst;
            sq_in.q   = sq_ff[j].q | (24'd1 << BIT);
         end
      end

      always_ff @(posedge clock) begin
         if (mv[SQ_BASE + 1 + j]) begin
            sq_ff[j+1] <= sq_in;
         end
      end
   end

   // Turn a vector in the left half plane by a quarter turn toward the right half.
   function automatic atrp_pkg::lane_type prerot(input logic signed [27:0] a,
                                                 input logic signed [27:0] b);
      atrp_pkg::lane_type r;
      r.zero = (a == 28'sd0) && (b == 28'sd0);
      r.x    = a;
      r.y    = b;
      r.ang  = '0;
      if (a < 28'sd0) begin
         if (b >= 28'sd0) begin
            r.x   = b;
            r.y   = -a;
            r.ang = atrp_pkg::DEG90;
         end else begin
            r.x   = -b;
            r.y   = a;
            r.ang = -atrp_pkg::DEG90;
         end
      end
      return r;
   endfunction

   function automatic atrp_pkg::lane_type cstep(input atrp_pkg::lane_type l,
                                                input logic [4:0] i);
      logic signed [27:0] dx, dy;
      atrp_pkg::lane_type r;
      dx = l.y >>> i;
      dy = l.x >>> i;
      r  = l;
      if (l.y > 28'sd0) begin
         r.x   = l.x + dx;
         r.y   = l.y - dy;
         r.ang = l.ang + atrp_pkg::ATAN_TAB[i];
      end else begin
         r.x   = l.x - dx;
         r.y   = l.y + dy;
         r.ang = l.ang - atrp_pkg::ATAN_TAB[i];
      end
      return r;
   endfunction

   atrp_pkg::cr_type cr_ff [0:NSTEPS];

   always_ff @(posedge clock) begin
      if (mv[CR_BASE]) begin
         cr_ff[0].ax    <= sq_ff[24].ax;
         cr_ff[0].ay    <= sq_ff[24].ay;
         cr_ff[0].az    <= sq_ff[24].az;
         cr_ff[0].roll  <= prerot(28'(sq_ff[24].az) <<< 8, 28'(sq_ff[24].ay) <<< 8);
         cr_ff[0].pitch <= prerot(28'({1'b0, sq_ff[24].q}), -(28'(sq_ff[24].ax) <<< 8));
      end
   end

   for (genvar j = 0; j < NSTEPS; j++) begin : g_cordic
      always_ff @(posedge clock) begin
         if (mv[CR_BASE + 1 + j]) begin
            cr_ff[j+1].ax    <= cr_ff[j].ax;
            cr_ff[j+1].ay    <= cr_ff[j].ay;
            cr_ff[j+1].az    <= cr_ff[j].az;
            cr_ff[j+1].roll  <= cstep(cr_ff[j].roll, 5'(j));
            cr_ff[j+1].pitch <= cstep(cr_ff[j].pitch, 5'(j));
         end
      end
   end

   // Round to 1/128 degree and clamp; a zero vector gives a zero angle.
   function automatic logic signed [16:0] finish(input atrp_pkg::lane_type l,
                                                 input logic signed [16:0] lim);
      logic signed [24:0] t;
      logic signed [16:0] r;
      t = (l.ang + 25'sd128) >>> 8;
      r = t[16:0];
      if (l.zero) begin
         r = '0;
      end else if (r > lim) begin
         r = lim;
      end else if (r < -lim) begin
         r = -lim;
      end
      return r;
   endfunction

   logic signed [16:0] roll_w, pitch_w;
   logic [79:0]        out_ff;

   assign roll_w  = finish(cr_ff[NSTEPS].roll, atrp_pkg::ROLL_LIMIT);
   assign pitch_w = finish(cr_ff[NSTEPS].pitch, atrp_pkg::PITCH_LIMIT);

   always_ff @(posedge clock) begin
      if (mv[NST-1]) begin
         out_ff <= {1'b0, pitch_w[14:0], roll_w[15:0], cr_ff[NSTEPS].az,
                    cr_ff[NSTEPS].ay, cr_ff[NSTEPS].ax};
      end
   end

   assign rsp_tvalid = vld_ff[NST-1];
   assign rsp_tdata  = out_ff;

endmodule

[rtl/atrp_checker.sv]
`timescale 1ns / 1ps
// Port-level checks for the accelerometer tilt block, bound to its top level.
// Depends on atrp_pkg and accel_tilt_roll_pitch_top.
module atrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata
);

   logic signed [15:0] roll;
   logic signed [14:0] pitch;

   assign roll  = rsp_tdata[63:48];
   assign pitch = rsp_tdata[78:64];

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   a_roll: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (17'(roll) <= atrp_pkg::ROLL_LIMIT) && (17'(roll) >= -atrp_pkg::ROLL_LIMIT))
      else $error("roll out of range");

   a_pitch: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (17'(pitch) <= atrp_pkg::PITCH_LIMIT)
                     && (17'(pitch) >= -atrp_pkg::PITCH_LIMIT))
      else $error("pitch out of range");

   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind accel_tilt_roll_pitch_top atrp_checker u_atrp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[dv/tb_accel_tilt_roll_pitch_top.sv]
`timescale 1ns / 1ps
// Self-checking testbench for accel_tilt_roll_pitch_top: sample words go in on the req
// stream, and each result word is compared with a tilt predictor in this file or a typed row.
// Depends on atrp_pkg and the RTL of the block.
module tb_accel_tilt_roll_pitch_top;

   localparam int STEPS       = 16;
   localparam int LATENCY     = 30 + STEPS;
   localparam int CYCLE_LIMIT = 400000;

   // Predictor's own copy of the atan(2^-i) table, in 1/32768 degree.
   localparam longint TILT_ATAN [0:23] = '{
      1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
      7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0
   };

   typedef struct packed {
      logic signed [15:0] ax, ay, az, roll;
      logic signed [14:0] pitch;
   } tilt_word_type;

   typedef struct {
      logic signed [15:0] x, y, z;
      bit                 typed;
      tilt_word_type      res;
   } sample_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [79:0] rsp_tdata;
   logic        csr_we = 0;
   logic        csr_addr = atrp_pkg::REG_AXIS_GAIN;
   logic [15:0] csr_wdata = '0;

   tilt_word_type expected_tilt [$];
   logic [15:0] gain_now;
   logic signed [15:0] offset_now;
   int  mismatches = 0;
   int  cycles = 0;
   bit  hold_rsp = 0;
   bit  rsp_stall_on = 1;

   accel_tilt_roll_pitch_top #(.CORDIC_STEPS(STEPS)) i_dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   function automatic longint floor_shift(longint v, int n);
      return v >>> n;
   endfunction

   function automatic longint sat16(longint v);
      return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
   endfunction

   function automatic longint scaled_axis(logic signed [15:0] raw);
      return sat16(floor_shift(longint'(raw) * longint'(gain_now) + 32768, 16));
   endfunction

   function automatic longint root_floor(longint n);
      longint r = 0;
      longint b = 64'sd1 <<< 60;
      while (b > n) b = b >>> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >>> 1) + b;
         end else begin
            r = r >>> 1;
         end
         b = b >>> 2;
      end
      return r;
   endfunction

   // Vectoring CORDIC; result in 1/128 degree before clamping.
   function automatic longint tilt_atan2(longint b, longint a);
      longint x = a;
      longint y = b;
      longint ang = 0;
      longint t, dx, dy;
      if (a == 0 && b == 0) return 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; ang = 2949120;
         end else begin
            x = -y; y = t; ang = -2949120;
         end
      end
      for (int i = 0; i < STEPS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (y > 0) begin
            x += dx; y -= dy; ang += TILT_ATAN[i];
         end else begin
            x -= dx; y += dy; ang -= TILT_ATAN[i];
         end
      end
      return floor_shift(ang + 128, 8);
   endfunction

   function automatic tilt_word_type predict_tilt(logic signed [15:0] rx, ry, rz);
      tilt_word_type w;
      longint ax, ay, az, mag, r, p;
      ax = scaled_axis(rx);
      ay = scaled_axis(ry);
      az = sat16(scaled_axis(rz) + longint'(offset_now));
      mag = root_floor((ay * ay + az * az) * 65536);
      r = tilt_atan2(ay * 256, az * 256);
      p = tilt_atan2(-ax * 256, mag);
      r = r < -23040 ? -23040 : (r > 23040 ? 23040 : r);
      p = p < -11520 ? -11520 : (p > 11520 ? 11520 : p);
      w.ax = 16'(ax); w.ay = 16'(ay); w.az = 16'(az); w.roll = 16'(r); w.pitch = 15'(p);
      return w;
   endfunction

   function automatic tilt_word_type typed_word(int ax, ay, az, roll, pitch);
      tilt_word_type w;
      w.ax = 16'(ax); w.ay = 16'(ay); w.az = 16'(az); w.roll = 16'(roll);
      w.pitch = 15'(pitch);
      return w;
   endfunction

   task automatic write_reg(logic idx, logic [15:0] val);
      csr_we    <= 1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 0;
      if (idx == atrp_pkg::REG_AXIS_GAIN) gain_now = val;
      else offset_now = val;
      @(posedge clock);
   endtask

   // Waits until the pipe has drained, then lets its latency pass once more.
   task automatic drain_pipe();
      while (expected_tilt.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_sample(logic signed [15:0] x, y, z, bit typed, tilt_word_type res);
      req_tvalid <= 1;
      req_tdata  <= {z, y, x};
      expected_tilt.push_back(typed ? res : predict_tilt(x, y, z));
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Bursts of random length with random gaps; valid stays up inside a burst.
   task automatic random_samples(int count);
      tilt_word_type none;
      int burst = 0;
      logic signed [15:0] x, y, z;
      none = '0;
      for (int n = 0; n < count; n++) begin
         if (burst == 0) begin
            if ($urandom_range(0, 2) != 0) begin
               req_tvalid <= 0;
               repeat ($urandom_range(1, 6)) @(posedge clock);
            end
            burst = $urandom_range(1, 20);
         end
         burst--;
         case ($urandom_range(0, 5))
            0: begin
               x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
            end
            1: begin
               x = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
               y = 16'($urandom_range(0, 200) - 100); z = 16'($urandom);
            end
            2: begin
               x = 16'sd0; y = 16'sd0;
               z = $urandom_range(0, 1) ? 16'sd0 : 16'($urandom);
            end
            default: begin
               x = 16'($urandom_range(0, 40000) - 20000);
               y = 16'($urandom_range(0, 40000) - 20000);
               z = 16'($urandom_range(0, 40000) - 20000);
            end
         endcase
         send_sample(x, y, z, 0, none);
      end
      req_tvalid <= 0;
   endtask

   // Receiver stall pattern, with an occasional long hold-off.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (reset || hold_rsp) rsp_tready <= 0;
      else if (!rsp_stall_on) rsp_tready <= 1;
      else rsp_tready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      tilt_word_type exp_w, got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ax    = rsp_tdata[15:0];
         got.ay    = rsp_tdata[31:16];
         got.az    = rsp_tdata[47:32];
         got.roll  = rsp_tdata[63:48];
         got.pitch = rsp_tdata[78:64];
         if (expected_tilt.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word: %h", rsp_tdata);
         end else begin
            exp_w = expected_tilt.pop_front();
            if (got != exp_w) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"word mismatch: exp ax %0d ay %0d az %0d roll %0d pitch %0d,",
                            " got ax %0d ay %0d az %0d roll %0d pitch %0d"},
                     exp_w.ax, exp_w.ay, exp_w.az, exp_w.roll, exp_w.pitch,
                     got.ax, got.ay, got.az, got.roll, got.pitch);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("** accel_tilt_roll_pitch_top: FAILED **");
         $finish;
      end
   end

   sample_row_type directed [] = '{
      '{16'sd0, 16'sd0, 16'sd0, 1, typed_word(0, 0, 282, 0, 0)},
      '{16'sd0, 16'sd0, -16'sd282, 0, '{default: 0}},
      '{16'sh7fff, 16'sh7fff, 16'sh7fff, 0, '{default: 0}},
      '{16'sh8000, 16'sh8000, 16'sh8000, 0, '{default: 0}},
      '{16'sh8000, 16'sd0, 16'sd0, 0, '{default: 0}},
      '{16'sh7fff, 16'sd0, 16'sd0, 0, '{default: 0}},
      '{16'sd0, 16'sd16500, 16'sd0, 0, '{default: 0}},
      '{16'sd0, -16'sd16500, 16'sd0, 0, '{default: 0}},
      '{16'sd0, 16'sd100, -16'sd16500, 0, '{default: 0}},
      '{16'sd0, -16'sd100, -16'sd16500, 0, '{default: 0}},
      '{16'sd0, 16'sd0, -16'sd16500, 0, '{default: 0}},
      '{-16'sd1, -16'sd1, -16'sd1, 0, '{default: 0}},
      '{16'sd1, 16'sd1, 16'sd1, 0, '{default: 0}},
      '{16'sh5555, 16'shaaaa, 16'sh5555, 0, '{default: 0}},
      '{16'shaaaa, 16'sh5555, 16'shaaaa, 0, '{default: 0}}
   };

   initial begin
      gain_now   = atrp_pkg::GAIN_RESET;
      offset_now = atrp_pkg::OFFSET_RESET;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      foreach (directed[i])
         send_sample(directed[i].x, directed[i].y, directed[i].z,
                     directed[i].typed, directed[i].res);
      random_samples(400);
      drain_pipe();

      // Long hold-off on the receiver so the pipe fills and stalls its input.
      fork
         begin
            hold_rsp = 1;
            repeat (300) @(posedge clock);
            hold_rsp = 0;
         end
         random_samples(150);
      join
      drain_pipe();

      // Largest gain and most negative offset; Z saturates low for negative samples.
      write_reg(atrp_pkg::REG_AXIS_GAIN, 16'hffff);
      write_reg(atrp_pkg::REG_Z_OFFSET, 16'h8000);
      random_samples(250);
      drain_pipe();
      write_reg(atrp_pkg::REG_AXIS_GAIN, 16'h0000);
      write_reg(atrp_pkg::REG_Z_OFFSET, 16'h7fff);
      random_samples(100);
      drain_pipe();
      rsp_stall_on = 0;
      write_reg(atrp_pkg::REG_AXIS_GAIN, 16'($urandom));
      write_reg(atrp_pkg::REG_Z_OFFSET, 16'($urandom));
      random_samples(300);
      drain_pipe();
      rsp_stall_on = 1;
      write_reg(atrp_pkg::REG_AXIS_GAIN, atrp_pkg::GAIN_RESET);
      write_reg(atrp_pkg::REG_Z_OFFSET, atrp_pkg::OFFSET_RESET);
      random_samples(450);
      drain_pipe();

      if (mismatches == 0 && expected_tilt.size() == 0)
         $display("** accel_tilt_roll_pitch_top: PASSED **");
      else
         $display("** accel_tilt_roll_pitch_top: FAILED **");
      $finish;
   end
endmodule
